[rtl/lsbsfd_pkg.sv]
// Shared types and constants for the LSB stego frame decoder.
// No dependencies; imported by every module of the block.
package lsbsfd_pkg;

    localparam int MAX_EXT_LEN_DEF   = 8;
    localparam int MAGIC_MAX_LEN_DEF = 8;

    localparam int MAGIC_W  = 64;
    localparam int MLEN_W   = 4;
    localparam int HLEN_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int WORD_W   = 32;
    localparam int EXT_W    = 8;
    localparam int BCNT_W   = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC_VALUE   = 2'd0,
        CFG_MAGIC_LENGTH  = 2'd1,
        CFG_HEADER_LENGTH = 2'd2
    } t_cfg_idx;

    localparam logic [MAGIC_W-1:0] MAGIC_VALUE_RST   = 64'd8998;
    localparam logic [MLEN_W-1:0]  MAGIC_LENGTH_RST  = 4'd2;
    localparam logic [HLEN_W-1:0]  HEADER_LENGTH_RST = 8'd54;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_MAGIC  = 3'd1,
        PH_EXTLEN = 3'd2,
        PH_EXT    = 3'd3,
        PH_PSIZE  = 3'd4,
        PH_PAY    = 3'd5,
        PH_IDLE   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        KIND_EXT_CHAR = 3'd0,
        KIND_PAYLOAD  = 3'd1,
        KIND_DONE     = 3'd2,
        KIND_MAGIC    = 3'd3,
        KIND_EXT_LONG = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [2:0] item_kind;
        logic       last;
    } t_result;

endpackage

[rtl/lsbsfd_parse.sv]
// Frame parser: config registers, header skip, bit gathering and field decode.
// Depends on lsbsfd_pkg. One request is processed per cycle while i_accept is high.
module lsbsfd_parse #(
    parameter int MAX_EXT_LEN   = lsbsfd_pkg::MAX_EXT_LEN_DEF,
    parameter int MAGIC_MAX_LEN = lsbsfd_pkg::MAGIC_MAX_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lsbsfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lsbsfd_pkg::MAGIC_W-1:0]      i_cfg_data,
    input  logic                                i_accept,
    input  logic [7:0]                          i_pixel_byte,
    input  logic                                i_frame_start,
    output logic                                o_res_valid,
    output lsbsfd_pkg::t_result                 o_res
);
    import lsbsfd_pkg::*;

    logic [MAGIC_W-1:0] r_magic_value;
    logic [MLEN_W-1:0]  r_magic_length;
    logic [HLEN_W-1:0]  r_header_length;

    t_phase             r_phase, n_phase;
    logic [HLEN_W-1:0]  r_hcnt, n_hcnt;
    logic [BCNT_W-1:0]  r_bcnt, n_bcnt;
    logic [WORD_W-1:0]  r_shift, n_shift;
    logic [7:0]         r_fidx, n_fidx;
    logic [EXT_W-1:0]   r_ext_len, n_ext_len;
    logic [WORD_W-1:0]  r_pay_rem, n_pay_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_value   <= MAGIC_VALUE_RST;
            r_magic_length  <= MAGIC_LENGTH_RST;
            r_header_length <= HEADER_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAGIC_VALUE:   r_magic_value   <= i_cfg_data;
                CFG_MAGIC_LENGTH:  r_magic_length  <= i_cfg_data[MLEN_W-1:0];
                CFG_HEADER_LENGTH: r_header_length <= i_cfg_data[HLEN_W-1:0];
                default: ;
            endcase
        end
    end

    logic [MLEN_W-1:0] eff_len;
    assign eff_len = (r_magic_length > MLEN_W'(MAGIC_MAX_LEN)) ?
                     MLEN_W'(MAGIC_MAX_LEN) : r_magic_length;

    always_comb begin
        t_phase            ph;
        logic [BCNT_W:0]   bc_inc;
        logic [WORD_W-1:0] gs;
        logic              done8, done32;
        logic [2:0]        midx;
        logic [7:0]        fi_inc;

        ph        = i_frame_start ? PH_HEADER : r_phase;
        n_hcnt    = i_frame_start ? '0 : r_hcnt;
        n_bcnt    = i_frame_start ? '0 : r_bcnt;
        n_shift   = i_frame_start ? '0 : r_shift;
        n_fidx    = i_frame_start ? '0 : r_fidx;
        n_ext_len = i_frame_start ? '0 : r_ext_len;
        n_pay_rem = i_frame_start ? '0 : r_pay_rem;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (ph == PH_HEADER && n_hcnt >= r_header_length) begin
            ph     = PH_MAGIC;
            n_fidx = '0;
            n_bcnt = '0;
        end
        if (ph == PH_MAGIC && eff_len == '0)
            ph = PH_EXTLEN;

        // shared bit gatherer
        bc_inc = {1'b0, n_bcnt} + 1'b1;
        gs     = {n_shift[WORD_W-2:0], i_pixel_byte[0]};
        done8  = bc_inc >= (BCNT_W+1)'(8);
        done32 = bc_inc >= (BCNT_W+1)'(32);
        midx   = eff_len[2:0] - 3'd1 - n_fidx[2:0];
        fi_inc = n_fidx + 8'd1;
        n_phase = ph;

        case (ph)
            PH_HEADER: begin
                n_hcnt = n_hcnt + 1'b1;
            end
            PH_MAGIC: begin
                n_shift = gs;
                n_bcnt  = done8 ? '0 : bc_inc[BCNT_W-1:0];
                if (done8) begin
                    if (gs[7:0] != r_magic_value[8*midx +: 8]) begin
                        n_phase     = PH_IDLE;
                        o_res_valid = 1'b1;
                        o_res       = '{8'd0, KIND_MAGIC, 1'b1};
                    end else begin
                        n_fidx = fi_inc;
                        if (fi_inc >= 8'(eff_len)) begin
                            n_phase = PH_EXTLEN;
                            n_fidx  = '0;
                        end
                    end
                end
            end
            PH_EXTLEN: begin
                n_shift = gs;
                n_bcnt  = done32 ? '0 : bc_inc[BCNT_W-1:0];
                if (done32) begin
                    if (gs > WORD_W'(MAX_EXT_LEN)) begin
                        n_phase     = PH_IDLE;
                        o_res_valid = 1'b1;
                        o_res       = '{8'd0, KIND_EXT_LONG, 1'b1};
                    end else begin
                        n_ext_len = gs[EXT_W-1:0];
                        n_fidx    = '0;
                        n_phase   = (gs != '0) ? PH_EXT : PH_PSIZE;
                    end
                end
            end
            PH_EXT: begin
                n_shift = gs;
                n_bcnt  = done8 ? '0 : bc_inc[BCNT_W-1:0];
                if (done8) begin
                    n_fidx = fi_inc;
                    if (fi_inc >= n_ext_len)
                        n_phase = PH_PSIZE;
                    o_res_valid = 1'b1;
                    o_res       = '{gs[7:0], KIND_EXT_CHAR, 1'b0};
                end
            end
            PH_PSIZE: begin
                n_shift = gs;
                n_bcnt  = done32 ? '0 : bc_inc[BCNT_W-1:0];
                if (done32) begin
                    if (gs == '0) begin
                        n_phase     = PH_IDLE;
                        o_res_valid = 1'b1;
                        o_res       = '{8'd0, KIND_DONE, 1'b1};
                    end else begin
                        n_pay_rem = gs;
                        n_phase   = PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                n_shift = gs;
                n_bcnt  = done8 ? '0 : bc_inc[BCNT_W-1:0];
                if (done8) begin
                    n_pay_rem   = n_pay_rem - 1'b1;
                    o_res_valid = 1'b1;
                    if (n_pay_rem == '0) begin
                        n_phase = PH_IDLE;
                        o_res   = '{gs[7:0], KIND_PAYLOAD, 1'b1};
                    end else begin
                        o_res   = '{gs[7:0], KIND_PAYLOAD, 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hcnt    <= '0;
            r_bcnt    <= '0;
            r_shift   <= '0;
            r_fidx    <= '0;
            r_ext_len <= '0;
            r_pay_rem <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_hcnt    <= n_hcnt;
            r_bcnt    <= n_bcnt;
            r_shift   <= n_shift;
            r_fidx    <= n_fidx;
            r_ext_len <= n_ext_len;
            r_pay_rem <= n_pay_rem;
        end
    end

endmodule

[rtl/lsbsfd_outq.sv]
// Two-entry result queue: output register plus skid slot.
// Depends on lsbsfd_pkg for the result struct.
module lsbsfd_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lsbsfd_pkg::t_result i_res,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output lsbsfd_pkg::t_result o_res
);
    import lsbsfd_pkg::*;

    t_result    r_q0, r_q1;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign pop     = (r_cnt != 2'd0) && !i_stall;
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_q0;

    always_comb begin
        n_cnt = r_cnt + 2'(i_push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q0 <= (r_cnt == 2'd2) ? r_q1 : i_res;
        end else if (i_push && r_cnt == 2'd0) begin
            r_q0 <= i_res;
        end
        if (i_push && !pop && r_cnt == 2'd1) begin
            r_q1 <= i_res;
        end
    end

endmodule

[rtl/lsb_stego_frame_decoder.sv]
// Top level of the LSB stego frame decoder: parser plus result queue.
// Depends on lsbsfd_pkg, lsbsfd_parse and lsbsfd_outq.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one image byte per request with
//   i_frame_start marking the first byte of a frame. Output channel
//   (o_valid / i_stall) carries decoded bytes and status items.
//   Config registers are written through i_cfg_we / i_cfg_index / i_cfg_data;
//   the user must write only while the block is idle (not enforced); writes take effect on the next request.
//   Throughput: one input request per cycle while o_stall is low, set by the
//   combinational parse step (shift one bit, update counters) between the state registers.
//   Output: a result is registered into the result queue when the input request
//   that completes it is accepted, and is presented on o_valid from the queue's output register.
//   Stall: a two-entry result queue absorbs one result while the receiver
//   stalls; o_stall rises only once both entries are occupied.
//   Reset: synchronous, active low; restores register defaults, empties the
//   queue and restarts the parse in header skip.
module lsb_stego_frame_decoder #(
    parameter int MAX_EXT_LEN   = lsbsfd_pkg::MAX_EXT_LEN_DEF,
    parameter int MAGIC_MAX_LEN = lsbsfd_pkg::MAGIC_MAX_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lsbsfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lsbsfd_pkg::MAGIC_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [7:0]                       i_pixel_byte,
    input  logic                             i_frame_start,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [7:0]                       o_data_byte,
    output logic [2:0]                       o_item_kind,
    output logic                             o_last
);
    import lsbsfd_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result q_res;
    logic    q_full;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    lsbsfd_parse #(
        .MAX_EXT_LEN   (MAX_EXT_LEN),
        .MAGIC_MAX_LEN (MAGIC_MAX_LEN)
    ) u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_pixel_byte  (i_pixel_byte),
        .i_frame_start (i_frame_start),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    lsbsfd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && res_valid),
        .i_res   (res),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (q_res)
    );

    assign o_data_byte = q_res.data_byte;
    assign o_item_kind = q_res.item_kind;
    assign o_last      = q_res.last;

endmodule
